// File: hw/rtl/pobft_pkg.sv
// shared types and codes of the per-owner byte fifo table
package pobft_pkg;

    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_UNKNOWN    = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    // slot field wide enough for the largest owner table
    localparam int CMD_SLOT_W = 6;

    typedef struct packed {
        logic [1:0]            opcode;
        logic                  have;
        logic [2:0]            status;
        logic [CMD_SLOT_W-1:0] slot;
        logic [7:0]            wbyte;
        logic                  fin;
    } t_cmd;

endpackage

// File: hw/rtl/pobft_front.sv
// front end: owner lookup, owner registration and command classification
module pobft_front #(
    parameter int MAX_OWNERS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_opcode,
    input  logic [31:0]      i_owner_id,
    input  logic [7:0]       i_write_byte,
    input  logic             i_final_byte,
    input  logic             i_q_full,
    output logic             o_push,
    output pobft_pkg::t_cmd  o_cmd
);

    localparam int SLOT_W = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int USED_W = $clog2(MAX_OWNERS + 1);

    logic [31:0]       r_tags [MAX_OWNERS];
    logic [USED_W-1:0] r_used;
    logic [USED_W-1:0] n_used;

    logic              w_found;
    logic [SLOT_W-1:0] w_fslot;
    logic              w_table_free;
    logic              w_reg_new;

    // lowest matching slot among the registered owners
    always_comb begin
        w_found = 1'b0;
        w_fslot = '0;
        for (int k = 0; k < MAX_OWNERS; k++) begin
            if (!w_found && (USED_W'(k) < r_used) && (r_tags[k] == i_owner_id)) begin
                w_found = 1'b1;
                w_fslot = SLOT_W'(k);
            end
        end
    end

    assign o_in_ready   = !i_q_full;
    assign o_push       = i_in_valid && !i_q_full;
    assign w_table_free = (r_used < USED_W'(MAX_OWNERS));
    assign w_reg_new    = (i_opcode == pobft_pkg::OP_OPEN) && !w_found && w_table_free;
    assign n_used       = r_used + USED_W'(1);

    always_comb begin
        o_cmd.opcode = i_opcode;
        o_cmd.wbyte  = i_write_byte;
        o_cmd.fin    = i_final_byte;
        o_cmd.have   = w_found || w_reg_new;
        o_cmd.slot   = w_found ? pobft_pkg::CMD_SLOT_W'(w_fslot)
                               : pobft_pkg::CMD_SLOT_W'(r_used[SLOT_W-1:0]);
        o_cmd.status = pobft_pkg::ST_OK;
        if (!w_found) begin
            if (i_opcode == pobft_pkg::OP_OPEN) begin
                if (!w_table_free) begin
                    o_cmd.status = pobft_pkg::ST_TABLE_FULL;
                end
            end else begin
                o_cmd.status = pobft_pkg::ST_UNKNOWN;
            end
        end
        if (!o_cmd.have) begin
            o_cmd.slot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (o_push && w_reg_new) begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push && w_reg_new) begin
            r_tags[r_used[SLOT_W-1:0]] <= i_owner_id;
        end
    end

endmodule

// File: hw/rtl/pobft_cmd_q.sv
// two-entry command queue between front and back end
module pobft_cmd_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pobft_pkg::t_cmd  i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output pobft_pkg::t_cmd  o_cmd
);

    pobft_pkg::t_cmd r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/pobft_back.sv
// back end: ring pointers, ring memory and result register
module pobft_back #(
    parameter int RING_DEPTH = 4096,
    parameter int MAX_OWNERS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  pobft_pkg::t_cmd  i_cmd,
    output logic             o_cmd_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [2:0]       o_status,
    output logic [7:0]       o_read_byte,
    output logic [12:0]      o_fill_level,
    output logic [2:0]       o_owner_slot,
    output logic             o_request_done
);

    localparam int SLOT_W = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int ADDR_W = $clog2(MAX_OWNERS * RING_DEPTH);
    localparam int MEM_D  = MAX_OWNERS * RING_DEPTH;

    localparam logic S_EXEC  = 1'b0;
    localparam logic S_RDATA = 1'b1;

    logic [7:0]       r_ring [MEM_D];
    logic [7:0]       r_rdata;
    logic [PTR_W-1:0] r_head [MAX_OWNERS];
    logic [PTR_W-1:0] r_tail [MAX_OWNERS];
    logic [CNT_W-1:0] r_cnt  [MAX_OWNERS];

    logic        r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_status, n_status;
    logic [7:0]  r_read_byte, n_read_byte;
    logic [12:0] r_fill, n_fill;
    logic [2:0]  r_slot, n_slot;
    logic        r_done, n_done;

    logic [PTR_W-1:0]  n_head, n_tail;
    logic [CNT_W-1:0]  n_cnt;
    logic [SLOT_W-1:0] w_slot;
    logic [PTR_W-1:0]  w_head, w_tail;
    logic [CNT_W-1:0]  w_cnt;
    logic [ADDR_W-1:0] w_base;
    logic              w_out_free;
    logic              w_we, w_re, w_upd;

    assign w_slot     = i_cmd.slot[SLOT_W-1:0];
    assign w_head     = r_head[w_slot];
    assign w_tail     = r_tail[w_slot];
    assign w_cnt      = r_cnt[w_slot];
    assign w_base     = ADDR_W'(w_slot) * ADDR_W'(RING_DEPTH);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_read_byte = r_read_byte;
        n_fill      = r_fill;
        n_slot      = r_slot;
        n_done      = r_done;
        n_head      = w_head;
        n_tail      = w_tail;
        n_cnt       = w_cnt;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_upd       = 1'b0;
        case (r_state)
            S_EXEC: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop   = 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = i_cmd.status;
                    n_read_byte = 8'd0;
                    n_fill      = 13'd0;
                    n_slot      = 3'd0;
                    n_done      = i_cmd.fin;
                    if (i_cmd.have) begin
                        n_slot = 3'(w_slot);
                        n_fill = 13'(w_cnt);
                        case (i_cmd.opcode)
                            pobft_pkg::OP_WRITE: begin
                                if (w_cnt == CNT_W'(RING_DEPTH)) begin
                                    n_status = pobft_pkg::ST_FULL;
                                end else begin
                                    w_we   = 1'b1;
                                    w_upd  = 1'b1;
                                    n_head = (w_head == PTR_W'(RING_DEPTH - 1))
                                           ? '0 : w_head + PTR_W'(1);
                                    n_cnt  = w_cnt + CNT_W'(1);
                                    n_fill = 13'(n_cnt);
                                end
                            end
                            pobft_pkg::OP_READ: begin
                                if (w_cnt == '0) begin
                                    n_status = pobft_pkg::ST_EMPTY;
                                end else begin
                                    w_re        = 1'b1;
                                    w_upd       = 1'b1;
                                    n_tail      = (w_tail == PTR_W'(RING_DEPTH - 1))
                                                ? '0 : w_tail + PTR_W'(1);
                                    n_cnt       = w_cnt - CNT_W'(1);
                                    n_fill      = 13'(n_cnt);
                                    n_out_valid = 1'b0;
                                    n_state     = S_RDATA;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_RDATA: begin
                n_read_byte = r_rdata;
                n_out_valid = 1'b1;
                n_state     = S_EXEC;
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EXEC;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_OWNERS; k++) begin
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_upd) begin
                r_head[w_slot] <= n_head;
                r_tail[w_slot] <= n_tail;
                r_cnt[w_slot]  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_read_byte <= n_read_byte;
        r_fill      <= n_fill;
        r_slot      <= n_slot;
        r_done      <= n_done;
    end

    // ring memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ring[w_base + ADDR_W'(w_head)] <= i_cmd.wbyte;
        end
        if (w_re) begin
            r_rdata <= r_ring[w_base + ADDR_W'(w_tail)];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_read_byte    = r_read_byte;
    assign o_fill_level   = r_fill;
    assign o_owner_slot   = r_slot;
    assign o_request_done = r_done;

endmodule

// File: hw/rtl/per_owner_byte_fifo_table.sv
// top level of the per-owner byte fifo table
// Each request gives exactly one result, in order. The front end looks up the
// owner id against the registered tags in the cycle the request is accepted
// and registers new owners there; it feeds a two-entry command queue and can
// accept a request every cycle while the queue has room. The back end takes
// one command per cycle for open, write and lookup; a successful read passes
// through the S_RDATA state, set by the registered ring memory read port,
// before the next command is taken. The ring memory is not cleared, so the
// block is ready right after reset. A result that is not taken holds the back
// end in place, while the queue keeps accepting requests until it fills.
module per_owner_byte_fifo_table #(
    parameter int RING_DEPTH = 4096,
    parameter int MAX_OWNERS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_owner_id,
    input  logic [7:0]  i_write_byte,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_read_byte,
    output logic [12:0] o_fill_level,
    output logic [2:0]  o_owner_slot,
    output logic        o_request_done
);

    pobft_pkg::t_cmd w_push_cmd;
    pobft_pkg::t_cmd w_pop_cmd;
    logic            w_push;
    logic            w_pop;
    logic            w_q_full;
    logic            w_q_valid;

    pobft_front #(
        .MAX_OWNERS (MAX_OWNERS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_owner_id   (i_owner_id),
        .i_write_byte (i_write_byte),
        .i_final_byte (i_final_byte),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    pobft_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_pop_cmd)
    );

    pobft_back #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_OWNERS (MAX_OWNERS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_q_valid),
        .i_cmd          (w_pop_cmd),
        .o_cmd_pop      (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_read_byte    (o_read_byte),
        .o_fill_level   (o_fill_level),
        .o_owner_slot   (o_owner_slot),
        .o_request_done (o_request_done)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_push)
        else $error("command pushed into a full queue");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("command popped from an empty queue");

    a_byte_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != pobft_pkg::ST_OK)) |-> (o_read_byte == 8'd0))
        else $error("read byte set on a failed request");

    a_no_slot_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_status == pobft_pkg::ST_UNKNOWN) ||
                         (o_status == pobft_pkg::ST_TABLE_FULL)))
        |-> ((o_fill_level == 13'd0) && (o_owner_slot == 3'd0)))
        else $error("slot reported for an unaddressed owner");

endmodule

// File: verif/per_owner_byte_fifo_table_checker.sv
// request/result checker and owner table predictor for the per-owner byte fifo table
`timescale 1ns / 100ps

module per_owner_byte_fifo_table_checker #(
    parameter int RING_DEPTH = 4096,
    parameter int MAX_OWNERS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_owner_id,
    input  logic [7:0]  i_write_byte,
    input  logic        i_final_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_read_byte,
    input  logic [12:0] i_fill_level,
    input  logic [2:0]  i_owner_slot,
    input  logic        i_request_done,
    output int          o_error_count,
    output int          o_pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  rbyte;
        logic [12:0] fill;
        logic [2:0]  slot;
        logic        done;
    } t_reply;

    t_reply      owed_results[$];
    logic [31:0] owner_tag [MAX_OWNERS];
    int unsigned owners_used;
    logic [7:0]  ring_mem [MAX_OWNERS*RING_DEPTH];
    int unsigned wr_pos [MAX_OWNERS];
    int unsigned rd_pos [MAX_OWNERS];
    int unsigned held [MAX_OWNERS];
    int          mismatches = 0;

    task automatic serve_request(input logic [1:0] op, input logic [31:0] id,
                                 input logic [7:0] data, input logic fin,
                                 output t_reply rep);
        int unsigned k;
        int unsigned slot;
        logic        found;
        slot  = 0;
        found = 1'b0;
        for (k = 0; k < owners_used; k++) begin
            if (!found && owner_tag[k] == id) begin
                found = 1'b1;
                slot  = k;
            end
        end
        rep        = '0;
        rep.done   = fin;
        rep.status = pobft_pkg::ST_OK;
        case (op)
            pobft_pkg::OP_OPEN: begin
                if (!found) begin
                    if (owners_used < MAX_OWNERS) begin
                        slot            = owners_used;
                        owner_tag[slot] = id;
                        wr_pos[slot]    = 0;
                        rd_pos[slot]    = 0;
                        held[slot]      = 0;
                        owners_used++;
                        found = 1'b1;
                    end else begin
                        rep.status = pobft_pkg::ST_TABLE_FULL;
                    end
                end
            end
            pobft_pkg::OP_WRITE: begin
                if (!found) begin
                    rep.status = pobft_pkg::ST_UNKNOWN;
                end else if (held[slot] >= RING_DEPTH) begin
                    rep.status = pobft_pkg::ST_FULL;
                end else begin
                    ring_mem[slot*RING_DEPTH + wr_pos[slot]] = data;
                    wr_pos[slot] = (wr_pos[slot] + 1) % RING_DEPTH;
                    held[slot]++;
                end
            end
            pobft_pkg::OP_READ: begin
                if (!found) begin
                    rep.status = pobft_pkg::ST_UNKNOWN;
                end else if (held[slot] == 0) begin
                    rep.status = pobft_pkg::ST_EMPTY;
                end else begin
                    rep.rbyte    = ring_mem[slot*RING_DEPTH + rd_pos[slot]];
                    rd_pos[slot] = (rd_pos[slot] + 1) % RING_DEPTH;
                    held[slot]--;
                end
            end
            default: begin
                // lookup only
                if (!found) rep.status = pobft_pkg::ST_UNKNOWN;
            end
        endcase
        if (found) begin
            rep.fill = 13'(held[slot]);
            rep.slot = 3'(slot);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_reply rep;
        if (!i_rst_n) begin
            owed_results.delete();
            owners_used = 0;
            for (int k = 0; k < MAX_OWNERS; k++) begin
                wr_pos[k] = 0;
                rd_pos[k] = 0;
                held[k]   = 0;
            end
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                serve_request(i_opcode, i_owner_id, i_write_byte, i_final_byte, rep);
                owed_results.push_back(rep);
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    rep = owed_results.pop_front();
                    if (i_status !== rep.status) begin
                        $error("status: expected %0d, got %0d", rep.status, i_status);
                        mismatches++;
                    end
                    if (i_read_byte !== rep.rbyte) begin
                        $error("read_byte: expected %0d, got %0d", rep.rbyte, i_read_byte);
                        mismatches++;
                    end
                    if (i_fill_level !== rep.fill) begin
                        $error("fill_level: expected %0d, got %0d", rep.fill, i_fill_level);
                        mismatches++;
                    end
                    if (i_owner_slot !== rep.slot) begin
                        $error("owner_slot: expected %0d, got %0d", rep.slot, i_owner_slot);
                        mismatches++;
                    end
                    if (i_request_done !== rep.done) begin
                        $error("request_done: expected %0d, got %0d", rep.done,
                               i_request_done);
                        mismatches++;
                    end
                end
            end
            o_pending <= owed_results.size();
        end
        o_error_count <= mismatches;
    end

endmodule

// File: verif/per_owner_byte_fifo_table_tb.sv
// stimulus and verdict for the per-owner byte fifo table
`timescale 1ns / 100ps

module per_owner_byte_fifo_table_tb;

    localparam int         RING_DEPTH   = 4096;
    localparam int         MAX_OWNERS   = 8;
    localparam int         RANDOM_ITEMS = 820;
    localparam int         STALL_BURST  = 24;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [1:0] OP_PROBE     = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_opcode = pobft_pkg::OP_OPEN;
    logic [31:0] i_owner_id = '0;
    logic [7:0]  i_write_byte = '0;
    logic        i_final_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_read_byte;
    logic [12:0] o_fill_level;
    logic [2:0]  o_owner_slot;
    logic        o_request_done;

    int          error_count;
    int          pending;
    int          cycles = 0;
    int          sent = 0;
    logic        steady = 1'b0;
    logic [31:0] known_ids [MAX_OWNERS];
    int          known_n = 0;

    per_owner_byte_fifo_table #(
        .RING_DEPTH(RING_DEPTH),
        .MAX_OWNERS(MAX_OWNERS)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_opcode(i_opcode), .i_owner_id(i_owner_id),
        .i_write_byte(i_write_byte), .i_final_byte(i_final_byte),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_read_byte(o_read_byte),
        .o_fill_level(o_fill_level), .o_owner_slot(o_owner_slot),
        .o_request_done(o_request_done)
    );

    per_owner_byte_fifo_table_checker #(
        .RING_DEPTH(RING_DEPTH),
        .MAX_OWNERS(MAX_OWNERS)
    ) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_opcode(i_opcode), .i_owner_id(i_owner_id),
        .i_write_byte(i_write_byte), .i_final_byte(i_final_byte),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_status(o_status), .i_read_byte(o_read_byte),
        .i_fill_level(o_fill_level), .i_owner_slot(o_owner_slot),
        .i_request_done(o_request_done),
        .o_error_count(error_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 19);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [31:0] id,
                                input logic [7:0] data, input logic fin);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < 19) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_owner_id   <= id;
        i_write_byte <= data;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_burst(input logic [1:0] op, input logic [31:0] id,
                              input int len, input bit broken);
        int k;
        for (k = 0; k < len; k++) begin
            send_request(op, id, 8'($urandom_range(255)),
                         broken ? 1'($urandom_range(1)) : (k == len - 1));
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          pick;
        int          len;
        int          start;
        bit          broken;
        logic [31:0] id;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases
        send_request(pobft_pkg::OP_OPEN, 32'h0000_0000, 8'h00, 1'b1);
        send_request(pobft_pkg::OP_OPEN, 32'hFFFF_FFFF, 8'hFF, 1'b0);
        send_request(pobft_pkg::OP_OPEN, 32'h0000_0000, 8'h5A, 1'b1);
        send_request(pobft_pkg::OP_WRITE, 32'h1234_5678, 8'h11, 1'b1);
        send_request(pobft_pkg::OP_READ, 32'h1234_5678, 8'h22, 1'b0);
        send_request(pobft_pkg::OP_READ, 32'h0000_0000, 8'h00, 1'b1);
        send_request(pobft_pkg::OP_WRITE, 32'h0000_0000, 8'h00, 1'b0);
        send_request(pobft_pkg::OP_WRITE, 32'h0000_0000, 8'hFF, 1'b1);
        send_request(pobft_pkg::OP_WRITE, 32'hFFFF_FFFF, 8'hAA, 1'b1);
        send_request(OP_PROBE, 32'hFFFF_FFFF, 8'h55, 1'b0);
        send_request(OP_PROBE, 32'hDEAD_0001, 8'h00, 1'b1);
        send_request(pobft_pkg::OP_READ, 32'h0000_0000, 8'h00, 1'b0);
        send_request(pobft_pkg::OP_READ, 32'h0000_0000, 8'hFF, 1'b1);
        send_request(pobft_pkg::OP_READ, 32'h0000_0000, 8'h00, 1'b1);
        send_request(pobft_pkg::OP_READ, 32'hFFFF_FFFF, 8'h00, 1'b1);
        send_request(pobft_pkg::OP_READ, 32'hFFFF_FFFF, 8'h00, 1'b1);
        known_ids[0] = 32'h0000_0000;
        known_ids[1] = 32'hFFFF_FFFF;
        known_n = 2;

        // write a stretch into one ring, hold off until all results are back, then drain it
        send_burst(pobft_pkg::OP_WRITE, 32'hFFFF_FFFF, STALL_BURST, 1'b0);
        wait_for_results();
        send_burst(pobft_pkg::OP_READ, 32'hFFFF_FFFF, STALL_BURST + 2, 1'b0);

        // random request bursts
        start = sent;
        while (sent - start < RANDOM_ITEMS) begin
            steady <= (sent - start >= 400) && (sent - start < 600);
            pick   = $urandom_range(99);
            len    = $urandom_range(1, 8);
            broken = ($urandom_range(9) == 0);
            id     = known_ids[$urandom_range(known_n - 1)];
            if (pick < 40) begin
                send_burst(pobft_pkg::OP_WRITE, id, len, broken);
            end else if (pick < 75) begin
                send_burst(pobft_pkg::OP_READ, id, len, broken);
            end else if (pick < 82) begin
                id = $urandom;
                if (known_n < MAX_OWNERS) begin
                    known_ids[known_n] = id;
                    known_n++;
                end
                send_request(pobft_pkg::OP_OPEN, id, 8'($urandom_range(255)),
                             1'($urandom_range(1)));
            end else if (pick < 87) begin
                send_request(pobft_pkg::OP_OPEN, id, 8'($urandom_range(255)),
                             1'($urandom_range(1)));
            end else if (pick < 93) begin
                send_burst(($urandom_range(1) == 0) ? pobft_pkg::OP_WRITE : pobft_pkg::OP_READ,
                           $urandom, len, broken);
            end else begin
                send_request(OP_PROBE, ($urandom_range(1) == 0) ? id : $urandom,
                             8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
        steady <= 1'b0;

        // more opens than the table holds
        repeat (MAX_OWNERS + 1) begin
            send_request(pobft_pkg::OP_OPEN, $urandom, 8'($urandom_range(255)), 1'b1);
        end
        send_request(pobft_pkg::OP_OPEN, known_ids[0], 8'h00, 1'b1);
        send_request(pobft_pkg::OP_WRITE, known_ids[1], 8'h3C, 1'b1);

        wait_for_results();
        repeat (20) @(posedge i_clk);

        $display("run covered %0d requests: corner cases, a ring written across a full stall",
                 sent);
        $display("and drained past empty, random bursts over %0d owners, opens on a full table",
                 known_n);
        if (error_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
